[rtl/core/lottery_priority_scheduler_top_macros.svh]
// Assertion macros for the lottery priority scheduler.
// Expects clk and rst_n in the scope of use.
`ifndef LOTTERY_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define LOTTERY_PRIORITY_SCHEDULER_TOP_MACROS_SVH
// Check a property on every clock edge outside reset.
`define LPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define LPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/lps_pkg.sv]
// Shared types, codes and constants of the lottery priority scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;
  localparam int SLOTS_DEF  = 32;
  localparam int QUEUES_DEF = 16;
  localparam int SLOT_W     = 5;
  localparam int PRIO_W     = 4;
  localparam int TK_W       = 5;
  localparam int VAL_W      = 5;
  localparam int DRAW_W     = 16;
  localparam int KIND_W     = 3;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DAT_W  = 5;
  localparam int TK_MAX     = 31;

  localparam logic [PRIO_W-1:0] WINQ_RST  = 4'd13;
  localparam logic [PRIO_W-1:0] WAITQ_RST = 4'd14;
  localparam logic [PRIO_W-1:0] LOWQ_RST  = 4'd15;
  localparam logic [TK_W-1:0]   INITK_RST = 5'd20;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 3'd0,
    KIND_INHERIT = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_OOQ     = 3'd3,
    KIND_NICE    = 3'd4,
    KIND_BALANCE = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_STATE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINQ  = 2'd0,
    CFG_WAITQ = 2'd1,
    CFG_LOWQ  = 2'd2,
    CFG_INITK = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVT, ST_LW, ST_SUM, ST_MOD, ST_PICK, ST_BAL, ST_DONE
  } state_t;

  typedef struct packed {
    logic              used;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] maxp;
    logic [TK_W-1:0]   tk;
    logic [TK_W-1:0]   lim;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_t;
endpackage
`default_nettype wire

[rtl/core/lottery_priority_scheduler_top.sv]
// Top level of the lottery priority scheduler: sequencer, output register, config.
// Depends on lps_pkg, lps_table, lps_mod and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lottery_priority_scheduler_top_macros.svh"
// One item at a time. An item that runs a lottery makes one table pass to move
// user slots to the waiting queue and sum their tickets, runs the bit-serial
// remainder unit, and makes one pass to find the winner; a balance tick takes one
// table pass. A result waits in the output register while out_tready is low, and
// the sequencer holds until it leaves. in_tready is high only between items.
// Configuration writes are always taken.
module lottery_priority_scheduler_top #(
  parameter int SLOTS  = lps_pkg::SLOTS_DEF,
  parameter int QUEUES = lps_pkg::QUEUES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // slot[4:0], value[9:5], random[25:10], zeros
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // slot_out[4:0], priority_out[8:5], is_winner[9],
                                       // status[11:10], zeros
  output logic [0:0]       out_tuser,  // record[0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOTW = $clog2(SLOTS * lps_pkg::TK_MAX + 1);

  lps_pkg::state_t state_r, state_nxt;
  logic [lps_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [lps_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [lps_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic [lps_pkg::DRAW_W-1:0] draw_r, draw_nxt;
  logic [lps_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [SW-1:0]   idx_r, idx_nxt, lw_r, lw_nxt, lwin_r, lwin_nxt;
  logic [TOTW-1:0] total_r, total_nxt, rest_r, rest_nxt, sum_now;
  logic [lps_pkg::PRIO_W-1:0] winq_r, waitq_r, lowq_r;
  logic [lps_pkg::TK_W-1:0]   initk_r;

  logic out_valid_r, out_valid_nxt, out_rec_r, out_rec_nxt, out_win_r, out_win_nxt;
  logic [lps_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [lps_pkg::PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [lps_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [SW-1:0] rd_addr;
  lps_pkg::entry_t rd, ent;
  lps_pkg::wr_t wr;
  logic mod_start, mod_done;
  logic [TOTW-1:0] mod_rem;
  logic can_emit, emit, rd_user, slot_ok, slot_used, big_val, is_last;
  logic [lps_pkg::PRIO_W:0] prio_inc;

  lps_table #(.SLOTS(SLOTS)) u_table (
    .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_data(rd), .wr(wr)
  );

  lps_mod #(.TOT_W(TOTW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .draw(draw_r),
    .total(sum_now), .done(mod_done), .rem(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      lwin_r      <= '0;
      winq_r      <= lps_pkg::WINQ_RST;
      waitq_r     <= lps_pkg::WAITQ_RST;
      lowq_r      <= lps_pkg::LOWQ_RST;
      initk_r     <= lps_pkg::INITK_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lwin_r      <= lwin_nxt;
      if (cfg_valid) begin
        case (lps_pkg::cfg_idx_t'(cfg_index))
          lps_pkg::CFG_WINQ:  winq_r  <= cfg_data[lps_pkg::PRIO_W-1:0];
          lps_pkg::CFG_WAITQ: waitq_r <= cfg_data[lps_pkg::PRIO_W-1:0];
          lps_pkg::CFG_LOWQ:  lowq_r  <= cfg_data[lps_pkg::PRIO_W-1:0];
          lps_pkg::CFG_INITK: initk_r <= cfg_data;
          default: ;
        endcase
      end
    end
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    value_r    <= value_nxt;
    draw_r     <= draw_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    lw_r       <= lw_nxt;
    total_r    <= total_nxt;
    rest_r     <= rest_nxt;
    out_rec_r  <= out_rec_nxt;
    out_win_r  <= out_win_nxt;
    out_slot_r <= out_slot_nxt;
    out_prio_r <= out_prio_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    case (state_r)
      lps_pkg::ST_EVT: rd_addr = slot_r[SW-1:0];
      lps_pkg::ST_LW:  rd_addr = lw_r;
      default:         rd_addr = idx_r;
    endcase
  end

  assign rd_user   = (rd.prio <= lowq_r) && (rd.prio >= winq_r);
  assign slot_ok   = {1'b0, slot_r} < (lps_pkg::SLOT_W + 1)'(SLOTS);
  assign slot_used = slot_ok && rd.used;
  assign big_val   = value_r >= lps_pkg::VAL_W'(QUEUES);
  assign is_last   = idx_r == SW'(SLOTS - 1);
  assign can_emit  = !out_valid_r || out_tready;
  assign prio_inc  = {1'b0, rd.prio} + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    slot_nxt     = slot_r;
    value_nxt    = value_r;
    draw_nxt     = draw_r;
    status_nxt   = status_r;
    idx_nxt      = idx_r;
    lw_nxt       = lw_r;
    lwin_nxt     = lwin_r;
    total_nxt    = total_r;
    rest_nxt     = rest_r;
    sum_now      = total_r;
    mod_start    = 1'b0;
    emit         = 1'b0;
    out_rec_nxt  = out_rec_r;
    out_win_nxt  = out_win_r;
    out_slot_nxt = out_slot_r;
    out_prio_nxt = out_prio_r;
    out_stat_nxt = out_stat_r;
    ent          = rd;
    wr           = '0;
    wr.addr      = lps_pkg::SLOT_W'(rd_addr);

    case (state_r)
      lps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          slot_nxt   = in_tdata[4:0];
          value_nxt  = in_tdata[9:5];
          draw_nxt   = in_tdata[25:10];
          kind_nxt   = in_tuser;
          status_nxt = lps_pkg::STAT_OK;
          state_nxt  = lps_pkg::ST_EVT;
        end
      end
      lps_pkg::ST_EVT: begin
        idx_nxt   = '0;
        total_nxt = '0;
        case (kind_r)
          lps_pkg::KIND_START, lps_pkg::KIND_INHERIT: begin
            if (!slot_ok || rd.used) begin
              status_nxt = lps_pkg::STAT_STATE;
              state_nxt  = lps_pkg::ST_DONE;
            end else if (big_val) begin
              status_nxt = lps_pkg::STAT_RANGE;
              state_nxt  = lps_pkg::ST_DONE;
            end else if (can_emit) begin
              ent.used = 1'b1;
              ent.maxp = value_r[lps_pkg::PRIO_W-1:0];
              ent.tk   = initk_r;
              ent.lim  = initk_r;
              ent.prio = (kind_r == lps_pkg::KIND_START) ?
                         value_r[lps_pkg::PRIO_W-1:0] : waitq_r;
              wr.we    = 1'b1;
              emit     = 1'b1;
              state_nxt = lps_pkg::ST_SUM;
            end
          end
          lps_pkg::KIND_STOP: begin
            if (!slot_used) begin
              status_nxt = lps_pkg::STAT_STATE;
              state_nxt  = lps_pkg::ST_DONE;
            end else begin
              ent.used  = 1'b0;
              wr.we     = 1'b1;
              state_nxt = lps_pkg::ST_SUM;
            end
          end
          lps_pkg::KIND_OOQ: begin
            if (!slot_used) begin
              status_nxt = lps_pkg::STAT_STATE;
              state_nxt  = lps_pkg::ST_DONE;
            end else if (can_emit) begin
              wr.we     = 1'b1;
              emit      = 1'b1;
              state_nxt = lps_pkg::ST_SUM;
              if (rd_user) begin
                ent.prio = waitq_r;
                if (rd.prio == winq_r) begin
                  if (rd.tk > lps_pkg::TK_W'(1)) ent.tk = rd.tk - 1'b1;
                end else begin
                  lw_nxt    = lwin_r;
                  state_nxt = lps_pkg::ST_LW;
                end
              end else if (prio_inc < {1'b0, winq_r}) begin
                ent.prio = prio_inc[lps_pkg::PRIO_W-1:0];
              end
            end
          end
          lps_pkg::KIND_NICE: begin
            if (!slot_used) begin
              status_nxt = lps_pkg::STAT_STATE;
              state_nxt  = lps_pkg::ST_DONE;
            end else if (big_val) begin
              status_nxt = lps_pkg::STAT_RANGE;
              state_nxt  = lps_pkg::ST_DONE;
            end else if (can_emit) begin
              if (rd_user) begin
                ent.lim = value_r;
                ent.tk  = value_r;
              end else begin
                ent.maxp = value_r[lps_pkg::PRIO_W-1:0];
                ent.prio = value_r[lps_pkg::PRIO_W-1:0];
              end
              wr.we     = 1'b1;
              emit      = 1'b1;
              state_nxt = lps_pkg::ST_SUM;
            end
          end
          lps_pkg::KIND_BALANCE: begin
            slot_nxt  = '0;
            state_nxt = lps_pkg::ST_BAL;
          end
          default: begin
            status_nxt = lps_pkg::STAT_RANGE;
            state_nxt  = lps_pkg::ST_DONE;
          end
        endcase
        out_slot_nxt = slot_r;
        out_prio_nxt = ent.prio;
        out_win_nxt  = 1'b0;
        out_rec_nxt  = 1'b0;
        out_stat_nxt = lps_pkg::STAT_OK;
      end
      lps_pkg::ST_LW: begin
        if (rd.tk < rd.lim) begin
          ent.tk = rd.tk + 1'b1;
          wr.we  = 1'b1;
        end
        state_nxt = lps_pkg::ST_SUM;
      end
      lps_pkg::ST_SUM: begin
        if (!(rd.used && rd_user && rd.prio != waitq_r) || can_emit) begin
          if (rd.used && rd_user) begin
            sum_now = total_r + TOTW'(rd.tk);
            if (rd.prio != waitq_r) begin
              ent.prio = waitq_r;
              wr.we    = 1'b1;
              emit     = 1'b1;
            end
          end
          total_nxt = sum_now;
          idx_nxt   = idx_r + 1'b1;
          if (is_last) begin
            idx_nxt = '0;
            if (sum_now == '0) begin
              state_nxt = lps_pkg::ST_DONE;
            end else begin
              mod_start = 1'b1;
              state_nxt = lps_pkg::ST_MOD;
            end
          end
        end
        out_slot_nxt = lps_pkg::SLOT_W'(idx_r);
        out_prio_nxt = waitq_r;
        out_win_nxt  = 1'b0;
        out_rec_nxt  = 1'b0;
        out_stat_nxt = lps_pkg::STAT_OK;
      end
      lps_pkg::ST_MOD: begin
        if (mod_done) begin
          rest_nxt  = mod_rem;
          idx_nxt   = '0;
          state_nxt = lps_pkg::ST_PICK;
        end
      end
      lps_pkg::ST_PICK: begin
        if (rd.used && rd_user && rd.prio == waitq_r) begin
          if (rest_r < TOTW'(rd.tk)) begin
            if (can_emit) begin
              ent.prio  = winq_r;
              wr.we     = 1'b1;
              emit      = 1'b1;
              lwin_nxt  = idx_r;
              state_nxt = lps_pkg::ST_DONE;
            end
          end else begin
            rest_nxt = rest_r - TOTW'(rd.tk);
            idx_nxt  = idx_r + 1'b1;
            if (is_last) state_nxt = lps_pkg::ST_DONE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (is_last) state_nxt = lps_pkg::ST_DONE;
        end
        out_slot_nxt = lps_pkg::SLOT_W'(idx_r);
        out_prio_nxt = winq_r;
        out_win_nxt  = 1'b1;
        out_rec_nxt  = 1'b0;
        out_stat_nxt = lps_pkg::STAT_OK;
      end
      lps_pkg::ST_BAL: begin
        if (!(rd.used && rd.prio > rd.maxp && !rd_user) || can_emit) begin
          if (rd.used && rd.prio > rd.maxp && !rd_user) begin
            ent.prio = rd.prio - 1'b1;
            wr.we    = 1'b1;
            emit     = 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          if (is_last) state_nxt = lps_pkg::ST_DONE;
        end
        out_slot_nxt = lps_pkg::SLOT_W'(idx_r);
        out_prio_nxt = ent.prio;
        out_win_nxt  = 1'b0;
        out_rec_nxt  = 1'b0;
        out_stat_nxt = lps_pkg::STAT_OK;
      end
      lps_pkg::ST_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = lps_pkg::ST_IDLE;
        end
        out_slot_nxt = slot_r;
        out_prio_nxt = '0;
        out_win_nxt  = 1'b0;
        out_rec_nxt  = 1'b1;
        out_stat_nxt = status_r;
      end
      default: state_nxt = lps_pkg::ST_IDLE;
    endcase

    wr.data = ent;
    if (emit)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
    if (!emit) begin
      out_rec_nxt  = out_rec_r;
      out_win_nxt  = out_win_r;
      out_slot_nxt = out_slot_r;
      out_prio_nxt = out_prio_r;
      out_stat_nxt = out_stat_r;
    end
  end

  assign in_tready  = state_r == lps_pkg::ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_stat_r, out_win_r, out_prio_r, out_slot_r};
  assign out_tuser  = out_rec_r;
  assign out_tlast  = out_rec_r;

  `LPS_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "ready after accept")
  `LPS_ASSERT(a_winner_is_notice, out_tvalid && out_win_r |-> !out_rec_r, "winner on record")
  `LPS_ASSERT(a_record_ok_status, out_tvalid && !out_rec_r |-> out_stat_r == lps_pkg::STAT_OK,
              "notice with nonzero status")
  `LPS_ASSERT(a_mod_only_in_lottery, mod_done |-> state_r == lps_pkg::ST_MOD,
              "remainder done outside lottery")
endmodule
`default_nettype wire

[rtl/core/lps_table.sv]
// Slot table: one entry per process slot, one read and one write port.
// Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lps_table #(
  parameter int SLOTS = lps_pkg::SLOTS_DEF,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [SW-1:0]   rd_addr,
  output lps_pkg::entry_t      rd_data,
  input  wire lps_pkg::wr_t    wr
);
  lps_pkg::entry_t mem_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) mem_r[i] <= '0;
    end else if (wr.we) begin
      mem_r[wr.addr[SW-1:0]] <= wr.data;
    end
  end

  assign rd_data = mem_r[rd_addr];
endmodule
`default_nettype wire

[rtl/core/lps_mod.sv]
// Bit-serial remainder unit: draw mod total, one quotient bit per cycle.
// Depends on lps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lottery_priority_scheduler_top_macros.svh"
module lps_mod #(
  parameter int TOT_W = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lps_pkg::DRAW_W-1:0] draw,
  input  wire logic [TOT_W-1:0]           total,
  output logic                            done,
  output logic [TOT_W-1:0]                rem
);
  localparam int CW = $clog2(lps_pkg::DRAW_W + 1);
  logic [lps_pkg::DRAW_W-1:0] q_r, q_nxt;
  logic [TOT_W-1:0] rem_r, rem_nxt, total_r, total_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [TOT_W:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    total_r <= total_nxt;
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    trial     = {rem_r, q_r[lps_pkg::DRAW_W-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = CW'(lps_pkg::DRAW_W);
      q_nxt     = draw;
      rem_nxt   = '0;
      total_nxt = total;
    end else if (busy_r) begin
      q_nxt = {q_r[lps_pkg::DRAW_W-2:0], 1'b0};
      if (trial >= {1'b0, total_r}) rem_nxt = TOT_W'(trial - {1'b0, total_r});
      else                           rem_nxt = trial[TOT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `LPS_ASSERT(a_rem_below_total, done_r |-> (rem_r < total_r), "remainder not below total")
  `LPS_ASSERT(a_no_restart, busy_r |-> !start, "remainder unit restarted while busy")
  `LPS_ASSERT(a_done_ends_busy, done_r |-> !busy_r, "done while still iterating")
endmodule
`default_nettype wire
